FILE: src/bmm_pkg.sv
// ----------------------------------------------------------------------------
// bmm_pkg: shared types and constants for the banked memory map block
// Operation, target and config codes, port numbers and the front-to-back item record.
// ----------------------------------------------------------------------------
package bmm_pkg;

	localparam int EepromWordsDefault = 1024;

	localparam logic [2:0] OP_MEM_RD  = 3'd0;
	localparam logic [2:0] OP_MEM_WR  = 3'd1;
	localparam logic [2:0] OP_PORT_IN = 3'd2;
	localparam logic [2:0] OP_PORT_OUT = 3'd3;
	localparam logic [2:0] OP_PRELOAD = 3'd4;

	localparam logic [2:0] T_WRAM = 3'd0;
	localparam logic [2:0] T_SRAM = 3'd1;
	localparam logic [2:0] T_ROM  = 3'd2;
	localparam logic [2:0] T_BOOT = 3'd3;
	localparam logic [2:0] T_NONE = 3'd4;
	localparam logic [2:0] T_PORT = 3'd5;

	localparam logic [1:0] CFG_LINEAR = 2'd0;
	localparam logic [1:0] CFG_SAVE   = 2'd1;
	localparam logic [1:0] CFG_SIZE   = 2'd2;

	localparam logic [15:0] P_EE_DATA = 16'h00BA;
	localparam logic [15:0] P_EE_CMD  = 16'h00BC;

	// classified item handed from the front to the back
	typedef struct packed {
		logic [2:0]  kind;      // T_* code or T_PORT / T_NONE
		logic        is_write;  // memory write or port out
		logic        is_wide;   // split port access
		logic        is_word;   // 0xBA/0xBC whole-word access
		logic        is_pre;    // EEPROM preload
		logic        need_mod;  // ROM offset must be reduced
		logic [32:0] offset;    // raw offset (ROM: before reduction)
		logic [15:0] port;
		logic [15:0] data;
		logic [23:0] addr;
	} item_t;

endpackage

FILE: src/bmm_ram.sv
// ----------------------------------------------------------------------------
// bmm_ram: generic single-port RAM with registered read
// One write or one read per cycle.
// ----------------------------------------------------------------------------
module bmm_ram #(
	parameter int Width = 16,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

FILE: src/bmm_front.sv
// ----------------------------------------------------------------------------
// bmm_front: accepts bus accesses and classifies them
// Decodes memory targets with the current bank settings, one item a cycle while the queue is not full.
// ----------------------------------------------------------------------------
module bmm_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        operation,
	input  logic [23:0]       address,
	input  logic [15:0]       port_number,
	input  logic [15:0]       write_data,
	input  logic              wide_access,
	input  logic [7:0]        linear_rom_bank,
	input  logic [7:0]        save_ram_bank,
	input  logic [7:0]        win0_bank,
	input  logic [7:0]        win1_bank,
	input  logic              boot_en,
	input  logic              q_full,
	output logic              q_push,
	output bmm_pkg::item_t    q_item
);
	import bmm_pkg::*;

	item_t it;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;
	assign q_item   = it;

	// memory, port and preload decode
	always_comb begin
		it = '0;
		it.port = port_number;
		it.data = write_data;
		it.addr = address;
		it.kind = T_NONE;
		it.is_wide = wide_access;
		it.is_word = wide_access && (port_number == P_EE_DATA || port_number == P_EE_CMD);
		unique case (operation)
			OP_MEM_RD, OP_MEM_WR: begin
				it.is_write = (operation == OP_MEM_WR);
				if (address < 24'h010000) begin
					it.kind = T_WRAM;
					it.offset = {9'd0, address};
				end else if (address < 24'h020000) begin
					it.kind = T_SRAM;
					it.offset = {9'd0, save_ram_bank, address[15:0]};
				end else if (operation == OP_MEM_WR) begin
					it.kind = T_NONE;
				end else if (address < 24'h030000) begin
					it.kind = T_ROM;
					it.need_mod = 1'b1;
					it.offset = {9'd0, win0_bank, address[15:0]};
				end else if (address < 24'h040000) begin
					it.kind = T_ROM;
					it.need_mod = 1'b1;
					it.offset = {9'd0, win1_bank, address[15:0]};
				end else if (boot_en && address >= 24'h0FE000 && address <= 24'h0FFFFF) begin
					it.kind = T_BOOT;
					it.offset = {20'd0, address[12:0]};
				end else begin
					it.kind = T_ROM;
					it.need_mod = 1'b1;
					it.offset = {5'd0, linear_rom_bank, 20'd0} + {9'd0, address};
				end
			end
			OP_PORT_IN: it.kind = T_PORT;
			OP_PORT_OUT: begin
				it.kind = T_PORT;
				it.is_write = 1'b1;
			end
			OP_PRELOAD: it.is_pre = 1'b1;
			default: it.kind = T_NONE;
		endcase
	end

	logic unused_clk;
	assign unused_clk = clk ^ arst_n;
endmodule

FILE: src/bmm_queue.sv
// ----------------------------------------------------------------------------
// bmm_queue: two-entry FIFO between front and back
// Registered entries; full and empty flags from a fill count.
// ----------------------------------------------------------------------------
module bmm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bmm_pkg::item_t push_item,
	input  logic           pop,
	output logic           full,
	output logic           empty,
	output bmm_pkg::item_t head
);
	import bmm_pkg::*;

	item_t      ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= push_item;
	end
endmodule

FILE: src/bmm_back.sv
// ----------------------------------------------------------------------------
// bmm_back: executes classified items
// Runs port register file, EEPROM commands and the ROM modulo reduction.
// ----------------------------------------------------------------------------
module bmm_back #(
	parameter int EepromWords = bmm_pkg::EepromWordsDefault
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  bmm_pkg::item_t q_head,
	output logic           q_pop,
	input  logic [24:0]    rom_size_bytes,
	output logic [7:0]     win0_bank,
	output logic [7:0]     win1_bank,
	output logic           boot_en,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [2:0]     target,
	output logic [23:0]    mem_offset,
	output logic           mem_write,
	output logic [7:0]     mem_data,
	output logic [15:0]    port_read_data,
	output logic           error
);
	import bmm_pkg::*;

	localparam int AW = $clog2(EepromWords);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LO   = 3'd1;  // first (or only) byte
	localparam logic [2:0] S_HI   = 3'd2;  // second byte of a split access
	localparam logic [2:0] S_MOD  = 3'd3;  // ROM reduction, one bit a cycle
	localparam logic [2:0] S_EE   = 3'd4;  // EEPROM read data returning
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0]  st_q;
	item_t       cur_q;
	logic [7:0]  spr_base_q, spr_first_q, spr_cnt_q, map_base_q, sys2_q, keysel_q;
	logic [7:0]  scroll_q [4];
	logic [7:0]  sys1_q, win0_q, win1_q, ee_stat_q;
	logic [15:0] ee_wr_q, ee_cmd_q, ee_rd_q;
	logic [15:0] rd_q;
	logic        err_q, ee_after_q;
	logic [24:0] rem_q;
	logic [4:0]  bit_q;
	logic [24:0] size_w;

	// outputs
	logic        ov_q;
	logic [2:0]  o_tgt_q;
	logic [23:0] o_off_q;
	logic        o_wr_q;
	logic [7:0]  o_dat_q;
	logic [15:0] o_rd_q;
	logic        o_err_q;

	// EEPROM store
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [15:0]   ram_rdata;

	bmm_ram #(.Width(16), .Depth(EepromWords)) u_ee (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(cur_q.data), .rdata(ram_rdata)
	);

	assign win0_bank = win0_q;
	assign win1_bank = win1_q;
	assign boot_en   = sys1_q[0];
	assign size_w    = (rom_size_bytes == 25'd0 || rom_size_bytes[24]) ?
		25'h1000000 : rom_size_bytes;
	assign q_pop     = (st_q == S_IDLE) && !q_empty;
	assign ram_we    = (st_q == S_LO) && cur_q.is_pre;
	assign ram_addr  = cur_q.is_pre ? cur_q.addr[AW-1:0] : ee_cmd_q[AW-1:0];

	assign out_valid      = ov_q;
	assign target         = o_tgt_q;
	assign mem_offset     = o_off_q;
	assign mem_write      = o_wr_q;
	assign mem_data       = o_dat_q;
	assign port_read_data = o_rd_q;
	assign error          = o_err_q;

	// byte port handling for the current half
	logic [15:0] pn;
	logic [7:0]  wb, rb;
	logic        perr, ee_go, ee_clr, ee_rdgo;
	always_comb begin
		pn = (st_q == S_HI) ? cur_q.port + 16'd1 : cur_q.port;
		wb = (st_q == S_HI) ? cur_q.data[15:8] : cur_q.data[7:0];
		rb = 8'd0;
		perr = 1'b0;
		ee_go = 1'b0;
		if (pn >= 16'h0080 && pn < 16'h009F) begin
			rb = 8'd0;
		end else begin
			case (pn)
				16'h0004: rb = spr_base_q;
				16'h0005: rb = spr_first_q;
				16'h0006: rb = spr_cnt_q;
				16'h0007: rb = map_base_q;
				16'h0010: rb = scroll_q[0];
				16'h0011: rb = scroll_q[1];
				16'h0012: rb = scroll_q[2];
				16'h0013: rb = scroll_q[3];
				16'h0060: rb = sys2_q;
				16'h00A0: rb = sys1_q;
				16'h00B5: rb = {4'd0, keysel_q[3:0]};
				16'h00BE: begin
					rb = ee_stat_q;
					ee_go = 1'b1;
				end
				16'h00C2: rb = win0_q;
				16'h00C3: rb = win1_q;
				default: perr = 1'b1;
			endcase
		end
		ee_clr  = (ee_cmd_q[11:10] == 2'd0) && (ee_cmd_q[9:8] == 2'd3);
		ee_rdgo = (ee_cmd_q[11:10] == 2'd2);
	end

	logic [25:0] trial;
	assign trial = {rem_q, cur_q.offset[bit_q]} - {1'b0, size_w};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ov_q <= 1'b0;
			spr_base_q <= '0; spr_first_q <= '0; spr_cnt_q <= '0; map_base_q <= '0;
			sys2_q <= '0; keysel_q <= '0; sys1_q <= 8'h8B;
			scroll_q[0] <= '0; scroll_q[1] <= '0; scroll_q[2] <= '0; scroll_q[3] <= '0;
			win0_q <= 8'hFF; win1_q <= 8'hFF; ee_stat_q <= 8'h83;
			ee_wr_q <= '0; ee_cmd_q <= '0; ee_rd_q <= '0;
		end else begin
			if (ov_q && !out_stall && st_q != S_OUT) ov_q <= 1'b0;
			unique case (st_q)
				S_IDLE: if (!q_empty) begin
					cur_q <= q_head;
					rd_q <= '0;
					err_q <= 1'b0;
					ee_after_q <= 1'b0;
					rem_q <= '0;
					bit_q <= 5'd31;
					st_q <= S_LO;
				end
				S_LO, S_HI: begin
					if (cur_q.kind != T_PORT) begin
						// window banks as left by every earlier port write
						if (cur_q.kind == T_ROM && cur_q.addr[23:18] == 6'd0)
							cur_q.offset <= {9'd0, cur_q.addr[16] ? win1_q : win0_q,
								cur_q.addr[15:0]};
						st_q <= cur_q.need_mod ? S_MOD : S_OUT;
						bit_q <= 5'd28;
					end else if (cur_q.is_word) begin
						if (!cur_q.is_write)
							rd_q <= (cur_q.port == P_EE_DATA) ? ee_rd_q : ee_cmd_q;
						else if (cur_q.port == P_EE_DATA) ee_wr_q <= cur_q.data;
						else ee_cmd_q <= cur_q.data;
						st_q <= S_OUT;
					end else begin
						if (!cur_q.is_write) begin
							if (st_q == S_HI) rd_q[15:8] <= rb;
							else rd_q[7:0] <= rb;
							err_q <= err_q | perr;
						end else if (!(pn >= 16'h0080 && pn < 16'h009F)) begin
							case (pn)
								16'h0004: spr_base_q <= wb;
								16'h0005: spr_first_q <= {1'b0, wb[6:0]};
								16'h0006: spr_cnt_q <= wb;
								16'h0007: map_base_q <= wb;
								16'h0010: scroll_q[0] <= wb;
								16'h0011: scroll_q[1] <= wb;
								16'h0012: scroll_q[2] <= wb;
								16'h0013: scroll_q[3] <= wb;
								16'h0060: sys2_q <= wb;
								16'h00A0: sys1_q[2] <= wb[2];
								16'h00B5: keysel_q <= wb;
								16'h00C2: win0_q <= wb;
								16'h00C3: win1_q <= wb;
								default: ;
							endcase
							err_q <= err_q | perr | (ee_go && !ee_clr && !ee_rdgo);
							if (ee_go && ee_clr) ee_stat_q[7] <= 1'b0;
							if (ee_go && ee_rdgo) ee_after_q <= 1'b1;
						end
						if (cur_q.is_wide && st_q == S_LO) st_q <= S_HI;
						else if ((ee_go && ee_rdgo && cur_q.is_write) || ee_after_q)
							st_q <= S_EE;
						else st_q <= S_OUT;
					end
				end
				S_MOD: begin
					// restoring reduction, one bit a cycle over 29 offset bits
					if (!trial[25]) rem_q <= trial[24:0];
					else rem_q <= {rem_q[23:0], cur_q.offset[bit_q]};
					if (bit_q == 5'd0) st_q <= S_OUT;
					else bit_q <= bit_q - 5'd1;
				end
				S_EE: begin
					ee_rd_q <= ram_rdata;
					st_q <= S_OUT;
				end
				S_OUT: if (!ov_q || !out_stall) begin
					ov_q <= 1'b1;
					o_tgt_q <= cur_q.kind;
					o_off_q <= (cur_q.kind == T_PORT || cur_q.kind == T_NONE) ? 24'd0 :
						cur_q.need_mod ? rem_q[23:0] : cur_q.offset[23:0];
					o_wr_q <= cur_q.is_write && cur_q.kind != T_PORT && cur_q.kind != T_NONE;
					o_dat_q <= (cur_q.is_write && cur_q.kind != T_PORT &&
						cur_q.kind != T_NONE) ? cur_q.data[7:0] : 8'd0;
					o_rd_q <= (cur_q.kind == T_PORT && !cur_q.is_write) ? rd_q : 16'd0;
					o_err_q <= err_q;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: src/banked_memory_map_and_io_ports_core.sv
// ----------------------------------------------------------------------------
// banked_memory_map_and_io_ports_core: memory map decoder and I/O port block
// Front decodes bus accesses, a two-entry queue feeds the back end.
//
// channel   direction  handshake        payload
// in        input      in_valid/stall   operation, address, port_number, ...
// out       output     out_valid/stall  target, mem_offset, ..., error
// cfg       input      valid/ready      cfg_index, cfg_data
//
// The back end takes one item at a time: a byte step, a second for split
// ports, an EEPROM read step after a read command and a bit-serial ROM
// modulo, then the registered result. Reset sets the control, port and
// config registers to defaults; the EEPROM store and data path are not
// cleared. Either side may stall; the queue holds two.
// ----------------------------------------------------------------------------
module banked_memory_map_and_io_ports_core #(
	parameter int EepromWords = bmm_pkg::EepromWordsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  operation,
	input  logic [23:0] address,
	input  logic [15:0] port_number,
	input  logic [15:0] write_data,
	input  logic        wide_access,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  target,
	output logic [23:0] mem_offset,
	output logic        mem_write,
	output logic [7:0]  mem_data,
	output logic [15:0] port_read_data,
	output logic        error,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [24:0] cfg_data
);
	import bmm_pkg::*;

	logic [7:0]  lin_q, save_q;
	logic [24:0] size_q;
	logic [7:0]  w0, w1;
	logic        boot_en, q_full, q_empty, q_push, q_pop;
	item_t       f_item, q_head;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_q  <= 8'hFF;
			save_q <= 8'hFF;
			size_q <= 25'h1000000;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_LINEAR: lin_q <= cfg_data[7:0];
				CFG_SAVE:   save_q <= cfg_data[7:0];
				CFG_SIZE:   size_q <= cfg_data;
				default: ;
			endcase
		end
	end

	bmm_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .address(address), .port_number(port_number),
		.write_data(write_data), .wide_access(wide_access),
		.linear_rom_bank(lin_q), .save_ram_bank(save_q), .win0_bank(w0),
		.win1_bank(w1), .boot_en(boot_en), .q_full(q_full), .q_push(q_push),
		.q_item(f_item)
	);

	bmm_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .push_item(f_item), .pop(q_pop),
		.full(q_full), .empty(q_empty), .head(q_head)
	);

	bmm_back #(.EepromWords(EepromWords)) u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop),
		.rom_size_bytes(size_q), .win0_bank(w0), .win1_bank(w1), .boot_en(boot_en),
		.out_valid(out_valid), .out_stall(out_stall), .target(target),
		.mem_offset(mem_offset), .mem_write(mem_write), .mem_data(mem_data),
		.port_read_data(port_read_data), .error(error)
	);

	// output valid holds under stall
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped under stall");
	// queue never over- or under-runs
	a_push: assert property (@(posedge clk) disable iff (!arst_n) !(q_push && q_full))
		else $error("queue overrun");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n) !(q_pop && q_empty))
		else $error("queue underrun");
endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: regression for the banked memory map and I/O port block
// Drives bus accesses through the stall handshake, predicts each result from
// a local copy of the port registers and bank settings, and checks every
// transfer field by field. Bank settings are changed between phases.
// ----------------------------------------------------------------------------
module tb;
	import bmm_pkg::*;

	localparam int EeWords = 1024;
	localparam longint CycleLimit = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] operation = '0;
	logic [23:0] address = '0;
	logic [15:0] port_number = '0;
	logic [15:0] write_data = '0;
	logic wide_access = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] target;
	logic [23:0] mem_offset;
	logic mem_write;
	logic [7:0] mem_data;
	logic [15:0] port_read_data;
	logic error;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [24:0] cfg_data = '0;

	typedef struct packed {
		logic [2:0] tgt;
		logic [23:0] offs;
		logic wr;
		logic [7:0] wdat;
		logic [15:0] rdat;
		logic err;
	} access_result_t;

	access_result_t expected_q[$];
	int fail_count = 0;
	longint cycle_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_off = 0;

	// predicted block state
	logic [7:0] lin_bank, save_bank;
	logic [24:0] rom_size;
	logic [7:0] spr_base, spr_first, spr_count, map_base, sys_two, sys_one, key_sel, ee_status;
	logic [7:0] scroll[4];
	logic [7:0] win_bank[2];
	logic [15:0] ee_wr_word, ee_cmd_word, ee_rd_word;
	logic [15:0] ee_store[EeWords];
	bit ee_written[EeWords];

	banked_memory_map_and_io_ports_core i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("banked_memory_map_and_io_ports_core regression: fail");
			$finish;
		end
	end

	// receiver stall, with an optional long hold-off
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		access_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$error("result transfer with nothing expected");
				fail_count++;
			end else begin
				exp_r = expected_q.pop_front();
				if (target !== exp_r.tgt) begin
					$error("target exp %0d got %0d", exp_r.tgt, target); fail_count++;
				end
				if (mem_offset !== exp_r.offs) begin
					$error("mem_offset exp %h got %h", exp_r.offs, mem_offset); fail_count++;
				end
				if (mem_write !== exp_r.wr) begin
					$error("mem_write exp %0d got %0d", exp_r.wr, mem_write); fail_count++;
				end
				if (mem_data !== exp_r.wdat) begin
					$error("mem_data exp %h got %h", exp_r.wdat, mem_data); fail_count++;
				end
				if (port_read_data !== exp_r.rdat) begin
					$error("port_read_data exp %h got %h", exp_r.rdat, port_read_data);
					fail_count++;
				end
				if (error !== exp_r.err) begin
					$error("error exp %0d got %0d", exp_r.err, error); fail_count++;
				end
			end
		end
	end

	function automatic logic [23:0] rom_wrap(input logic [32:0] raw);
		logic [32:0] sz;
		sz = (rom_size == 0 || rom_size > 25'h1000000) ? 33'h1000000 : 33'(rom_size);
		return 24'(raw % sz);
	endfunction

	function automatic logic [7:0] narrow_read(input logic [15:0] p, inout logic err);
		if (p >= 16'h80 && p < 16'h9F) return 8'h00;
		case (p)
			16'h04: return spr_base;
			16'h05: return spr_first;
			16'h06: return spr_count;
			16'h07: return map_base;
			16'h10: return scroll[0];
			16'h11: return scroll[1];
			16'h12: return scroll[2];
			16'h13: return scroll[3];
			16'h60: return sys_two;
			16'hA0: return sys_one;
			16'hB5: return {4'h0, key_sel[3:0]};
			16'hBE: return ee_status;
			16'hC2: return win_bank[0];
			16'hC3: return win_bank[1];
			default: begin
				err = 1'b1;
				return 8'h00;
			end
		endcase
	endfunction

	// runs the latched EEPROM command; returns 1 when unsupported
	function automatic logic ee_command();
		logic [1:0] opc;
		opc = ee_cmd_word[11:10];
		if (opc == 2'd0 && ee_cmd_word[9:8] == 2'd3) begin
			ee_status[7] = 1'b0;
			return 1'b0;
		end
		if (opc == 2'd2) begin
			ee_rd_word = ee_store[ee_cmd_word[9:0] % EeWords];
			return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic logic narrow_write(input logic [15:0] p, input logic [7:0] b);
		if (p >= 16'h80 && p < 16'h9F) return 1'b0;
		case (p)
			16'h04: spr_base = b;
			16'h05: spr_first = {1'b0, b[6:0]};
			16'h06: spr_count = b;
			16'h07: map_base = b;
			16'h10: scroll[0] = b;
			16'h11: scroll[1] = b;
			16'h12: scroll[2] = b;
			16'h13: scroll[3] = b;
			16'h60: sys_two = b;
			16'hA0: sys_one[2] = b[2];
			16'hB5: key_sel = b;
			16'hBE: return ee_command();
			16'hC2: win_bank[0] = b;
			16'hC3: win_bank[1] = b;
			default: return 1'b1;
		endcase
		return 1'b0;
	endfunction

	function automatic access_result_t predict_access(input logic [2:0] op, input logic [23:0] a,
			input logic [15:0] p, input logic [15:0] d, input logic w);
		access_result_t r;
		logic e1, e2;
		r = '0;
		r.tgt = T_NONE;
		e1 = 1'b0;
		e2 = 1'b0;
		if (op == OP_MEM_RD || op == OP_MEM_WR) begin
			if (a < 24'h10000) begin
				r.tgt = T_WRAM;
				r.offs = a;
			end else if (a < 24'h20000) begin
				r.tgt = T_SRAM;
				r.offs = {save_bank, a[15:0]};
			end else if (op == OP_MEM_WR) begin
				r.tgt = T_NONE;
			end else if (a < 24'h30000) begin
				r.tgt = T_ROM;
				r.offs = rom_wrap({17'd0, win_bank[0], a[15:0]});
			end else if (a < 24'h40000) begin
				r.tgt = T_ROM;
				r.offs = rom_wrap({17'd0, win_bank[1], a[15:0]});
			end else if (sys_one[0] && a >= 24'hFE000 && a <= 24'hFFFFF) begin
				r.tgt = T_BOOT;
				r.offs = a - 24'hFE000;
			end else begin
				r.tgt = T_ROM;
				r.offs = rom_wrap(({25'd0, lin_bank} << 20) + 33'(a));
			end
			if (op == OP_MEM_WR && r.tgt != T_NONE) begin
				r.wr = 1'b1;
				r.wdat = d[7:0];
			end
		end else if (op == OP_PORT_IN) begin
			r.tgt = T_PORT;
			if (w && p == P_EE_DATA) r.rdat = ee_rd_word;
			else if (w && p == P_EE_CMD) r.rdat = ee_cmd_word;
			else if (w) begin
				r.rdat[7:0] = narrow_read(p, e1);
				r.rdat[15:8] = narrow_read(p + 16'd1, e1);
			end else r.rdat[7:0] = narrow_read(p, e1);
			r.err = e1;
		end else if (op == OP_PORT_OUT) begin
			r.tgt = T_PORT;
			if (w && p == P_EE_DATA) ee_wr_word = d;
			else if (w && p == P_EE_CMD) ee_cmd_word = d;
			else if (w) begin
				e1 = narrow_write(p, d[7:0]);
				e2 = narrow_write(p + 16'd1, d[15:8]);
			end else e1 = narrow_write(p, d[7:0]);
			r.err = e1 | e2;
		end else if (op == OP_PRELOAD) begin
			ee_store[a % EeWords] = d;
			ee_written[a % EeWords] = 1'b1;
		end
		return r;
	endfunction

	task automatic send_access(input logic [2:0] op, input logic [23:0] a,
			input logic [15:0] p, input logic [15:0] d, input logic w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		address <= a;
		port_number <= p;
		write_data <= d;
		wide_access <= w;
		do @(posedge clk); while (in_stall);
		expected_q.push_back(predict_access(op, a, p, d, w));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_bank_reg(input logic [1:0] idx, input logic [24:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_LINEAR: lin_bank = val[7:0];
			CFG_SAVE: save_bank = val[7:0];
			default: rom_size = val;
		endcase
		@(posedge clk);
	endtask

	// EEPROM read command; only words already preloaded are addressed
	function automatic logic [15:0] safe_command(input logic [15:0] raw);
		logic [15:0] c;
		c = raw;
		if (c[11:10] == 2'd2 && !ee_written[c[9:0] % EeWords]) begin
			// fall back to an unsupported command when nothing is preloaded
			c[11:10] = 2'd3;
			for (int i = 0; i < EeWords; i++) begin
				if (ee_written[i]) begin
					c[9:0] = 10'(i);
					c[11:10] = 2'd2;
					break;
				end
			end
		end
		return c;
	endfunction

	task automatic random_access();
		logic [2:0] op;
		logic [23:0] a;
		logic [15:0] p, d;
		logic w;
		int k;
		k = $urandom_range(99);
		a = 24'($urandom);
		d = 16'($urandom);
		w = 1'($urandom);
		p = 16'($urandom);
		if (k < 30) begin
			op = 3'($urandom_range(1));
			case ($urandom_range(4))
				0: a = 24'($urandom_range(24'h3FFFF));
				1: a = 24'(24'hFE000 + $urandom_range(24'h1FFF));
				default: ;
			endcase
		end else if (k < 80) begin
			op = 3'($urandom_range(OP_PORT_OUT, OP_PORT_IN));
			case ($urandom_range(5))
				0: p = 16'(16'h80 + $urandom_range(31));
				1, 2: p = 16'($urandom_range(16'hC3));
				3: p = $urandom_range(1) ? P_EE_DATA : P_EE_CMD;
				4: p = 16'hBE;
				default: ;
			endcase
			if (op == OP_PORT_OUT && w && p == P_EE_CMD) d = safe_command(d);
		end else if (k < 95) begin
			op = OP_PRELOAD;
		end else begin
			op = 3'($urandom_range(7, 5));
		end
		send_access(op, a, p, d, w);
	endtask

	task automatic test_directed();
		send_access(OP_MEM_RD, 24'h000000, 0, 0, 0);
		send_access(OP_MEM_WR, 24'h00FFFF, 0, 16'hFFA5, 0);
		send_access(OP_MEM_WR, 24'h010000, 0, 16'h005A, 0);
		send_access(OP_MEM_RD, 24'h02ABCD, 0, 0, 0);
		send_access(OP_MEM_RD, 24'h03FFFF, 0, 0, 0);
		send_access(OP_MEM_WR, 24'h035555, 0, 16'h1234, 0);
		send_access(OP_MEM_RD, 24'h0FE000, 0, 0, 0);
		send_access(OP_MEM_RD, 24'hFFFFFF, 0, 0, 0);
		send_access(OP_MEM_RD, 24'h1FFFFF, 0, 0, 0);
		send_access(OP_PORT_OUT, 24'h0, 16'hA0, 16'hFFFE, 0);
		send_access(OP_MEM_RD, 24'h0FFFFF, 0, 0, 0);
		send_access(OP_PORT_OUT, 24'h0, 16'h04, 16'hFF7F, 1);
		send_access(OP_PORT_IN, 24'h0, 16'h04, 0, 1);
		send_access(OP_PORT_IN, 24'h0, 16'h85, 0, 0);
		send_access(OP_PORT_OUT, 24'h0, 16'h9E, 16'hFFFF, 0);
		send_access(OP_PORT_IN, 24'h0, 16'hFFFF, 0, 1);
		send_access(OP_PORT_OUT, 24'h0, 16'h0003, 16'hFFFF, 1);
		send_access(OP_PORT_OUT, 24'h0, 16'hB5, 16'h00FF, 0);
		send_access(OP_PORT_IN, 24'h0, 16'hB5, 0, 0);
		send_access(OP_PRELOAD, 24'hFFFFFF, 0, 16'hBEEF, 0);
		send_access(OP_PORT_OUT, 24'h0, P_EE_CMD, 16'h0BFF, 1);
		send_access(OP_PORT_OUT, 24'h0, 16'hBE, 0, 0);
		send_access(OP_PORT_IN, 24'h0, P_EE_DATA, 0, 1);
		send_access(OP_PORT_OUT, 24'h0, P_EE_CMD, 16'h0300, 1);
		send_access(OP_PORT_OUT, 24'h0, 16'hBE, 0, 0);
		send_access(OP_PORT_OUT, 24'h0, P_EE_CMD, 16'h0C00, 1);
		send_access(OP_PORT_OUT, 24'h0, 16'hBE, 0, 0);
		send_access(OP_PORT_OUT, 24'h0, P_EE_DATA, 16'hFFFF, 1);
		send_access(7, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 1);
		drain_results();
	endtask

	task automatic test_random_phases();
		logic [24:0] sizes[6];
		sizes = '{25'd1, 25'h1000000, 25'h1FFFFFF, 25'd0, 25'h12345, 25'h80000};
		for (int ph = 0; ph < 6; ph++) begin
			write_bank_reg(CFG_LINEAR, ph == 0 ? 25'd0 : (ph == 1 ? 25'hFF : $urandom_range(255)));
			write_bank_reg(CFG_SAVE, ph == 0 ? 25'hFF : (ph == 1 ? 25'd0 : $urandom_range(255)));
			write_bank_reg(CFG_SIZE, sizes[ph]);
			send_idle_pct = (ph < 2) ? 35 : (ph < 4 ? 83 : 0);
			recv_idle_pct = (ph < 2) ? 83 : (ph < 4 ? 35 : 0);
			repeat (170) random_access();
			drain_results();
		end
	endtask

	task automatic test_back_pressure();
		hold_off = 300;
		repeat (20) random_access();
		drain_results();
		repeat (10) random_access();
	endtask

	initial begin
		lin_bank = 8'hFF;
		save_bank = 8'hFF;
		rom_size = 25'h1000000;
		{spr_base, spr_first, spr_count, map_base, sys_two, key_sel} = '0;
		scroll = '{default: 8'h00};
		sys_one = 8'h8B;
		win_bank = '{8'hFF, 8'hFF};
		{ee_wr_word, ee_cmd_word, ee_rd_word} = '0;
		ee_status = 8'h83;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_phases();
		test_back_pressure();
		drain_results();
		if (fail_count == 0 && expected_q.size() == 0)
			$display("banked_memory_map_and_io_ports_core regression: pass");
		else
			$display("banked_memory_map_and_io_ports_core regression: fail");
		$finish;
	end

endmodule
